/* design/w2rgb_pkg.sv */
// Shared types, constants and segment tables for the wavelength to RGB pipeline.
// No dependencies; every other file in the design imports this package.
`timescale 1ns / 1ps

package w2rgb_pkg;

  // Field widths.
  localparam int WL_W    = 10;
  localparam int CHAN_W  = 8;
  localparam int NUM_W   = 7;   // colour numerator, at most 70
  localparam int INTEN_W = 10;  // edge intensity in units of 1/800, at most 800
  localparam int PROD_W  = 17;  // numerator times intensity, below 2^17
  localparam int N2_W    = 25;  // doubled scaled numerator plus bias, below 2^25
  localparam int RECIP_W = 15;  // reciprocal of the doubled denominator
  localparam int DIV_W   = 17;  // doubled denominator, 1600 * den
  localparam int BIAS_W  = 16;  // rounding bias, 800 * den
  localparam int Q_W     = 9;   // quotient estimate with headroom
  localparam int REM_W   = 26;  // width of quotient times divisor

  // Shift that goes with the reciprocals below; 2^25 exceeds the largest dividend,
  // so the estimate is low by at most one.
  localparam int RECIP_SHIFT = 25;

  // Wavelength break points in nanometres.
  localparam logic [WL_W-1:0] WL_MIN    = 10'd380;
  localparam logic [WL_W-1:0] WL_RAMP_LO = 10'd420;
  localparam logic [WL_W-1:0] WL_VIOLET = 10'd440;
  localparam logic [WL_W-1:0] WL_BLUE   = 10'd490;
  localparam logic [WL_W-1:0] WL_CYAN   = 10'd510;
  localparam logic [WL_W-1:0] WL_GREEN  = 10'd580;
  localparam logic [WL_W-1:0] WL_YELLOW = 10'd645;
  localparam logic [WL_W-1:0] WL_RAMP_HI = 10'd700;
  localparam logic [WL_W-1:0] WL_MAX    = 10'd780;

  // Edge intensity: floor 0.3 and full scale 1.0, in units of 1/800.
  localparam logic [INTEN_W-1:0] INTEN_FLOOR = 10'd240;
  localparam logic [INTEN_W-1:0] INTEN_FULL  = 10'd800;
  localparam logic [INTEN_W-1:0] INTEN_STEP_HI = 10'd7;
  localparam logic [INTEN_W-1:0] INTEN_STEP_LO = 10'd14;

  // Segment denominators.
  localparam int DEN_VIOLET = 60;
  localparam int DEN_BLUE   = 50;
  localparam int DEN_CYAN   = 20;
  localparam int DEN_GREEN  = 70;
  localparam int DEN_YELLOW = 65;
  localparam int DEN_RED    = 1;

  localparam int INT_DEN = 800;

  localparam int RECIP_VIOLET = (1 << RECIP_SHIFT) / (2 * INT_DEN * DEN_VIOLET);
  localparam int RECIP_BLUE   = (1 << RECIP_SHIFT) / (2 * INT_DEN * DEN_BLUE);
  localparam int RECIP_CYAN   = (1 << RECIP_SHIFT) / (2 * INT_DEN * DEN_CYAN);
  localparam int RECIP_GREEN  = (1 << RECIP_SHIFT) / (2 * INT_DEN * DEN_GREEN);
  localparam int RECIP_YELLOW = (1 << RECIP_SHIFT) / (2 * INT_DEN * DEN_YELLOW);
  localparam int RECIP_RED    = (1 << RECIP_SHIFT) / (2 * INT_DEN * DEN_RED);

  // Colour segment of the spectrum. Out-of-range input uses SEG_RED with zero numerators.
  typedef enum logic [2:0] {
    SEG_VIOLET,
    SEG_BLUE,
    SEG_CYAN,
    SEG_GREEN,
    SEG_YELLOW,
    SEG_RED
  } seg_t;

  // Decoded item handed from the decode stage to the channel pipelines.
  typedef struct packed {
    seg_t               seg;
    logic [NUM_W-1:0]   red_num;
    logic [NUM_W-1:0]   grn_num;
    logic [NUM_W-1:0]   blu_num;
    logic [INTEN_W-1:0] inten;
  } dec_t;

  // Segment denominator as a numerator value (full colour).
  function automatic logic [NUM_W-1:0] seg_den(seg_t s);
    logic [NUM_W-1:0] d;
    unique case (s)
      SEG_VIOLET: d = NUM_W'(DEN_VIOLET);
      SEG_BLUE:   d = NUM_W'(DEN_BLUE);
      SEG_CYAN:   d = NUM_W'(DEN_CYAN);
      SEG_GREEN:  d = NUM_W'(DEN_GREEN);
      SEG_YELLOW: d = NUM_W'(DEN_YELLOW);
      SEG_RED:    d = NUM_W'(DEN_RED);
      default:    d = NUM_W'(DEN_RED);
    endcase
    return d;
  endfunction

  // Rounding bias, 800 * den.
  function automatic logic [BIAS_W-1:0] seg_bias(seg_t s);
    return BIAS_W'(INT_DEN * int'(seg_den(s)));
  endfunction

  // Doubled denominator, 1600 * den.
  function automatic logic [DIV_W-1:0] seg_div(seg_t s);
    return DIV_W'(2 * INT_DEN * int'(seg_den(s)));
  endfunction

  // floor(2^RECIP_SHIFT / (1600 * den)).
  function automatic logic [RECIP_W-1:0] seg_recip(seg_t s);
    logic [RECIP_W-1:0] r;
    unique case (s)
      SEG_VIOLET: r = RECIP_W'(RECIP_VIOLET);
      SEG_BLUE:   r = RECIP_W'(RECIP_BLUE);
      SEG_CYAN:   r = RECIP_W'(RECIP_CYAN);
      SEG_GREEN:  r = RECIP_W'(RECIP_GREEN);
      SEG_YELLOW: r = RECIP_W'(RECIP_YELLOW);
      SEG_RED:    r = RECIP_W'(RECIP_RED);
      default:    r = RECIP_W'(RECIP_RED);
    endcase
    return r;
  endfunction

endpackage

/* design/w2rgb_if.sv */
// Valid/ready channel interfaces for the wavelength input and the RGB result.
// Depends on w2rgb_pkg for the field widths.
`timescale 1ns / 1ps

interface w2rgb_in_if;
  import w2rgb_pkg::*;
  logic            valid;
  logic            ready;
  logic [WL_W-1:0] wavelength_nm;

  modport source (output valid, output wavelength_nm, input ready);
  modport sink   (input valid, input wavelength_nm, output ready);
endinterface

interface w2rgb_out_if;
  import w2rgb_pkg::*;
  logic              valid;
  logic              ready;
  logic [CHAN_W-1:0] red;
  logic [CHAN_W-1:0] green;
  logic [CHAN_W-1:0] blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

/* design/wavelength_to_rgb_unit.sv */
// Top level of the wavelength to RGB colour map: decode stage, three channel
// pipelines and the valid chain. Depends on w2rgb_pkg, w2rgb_if, w2rgb_decode, w2rgb_chan.
//
//   Channel   Role      Payload                  Transfer when
//   in_ch     sink      wavelength_nm[9:0]       in_ch.valid && in_ch.ready
//   out_ch    source    red, green, blue [7:0]   out_ch.valid && out_ch.ready
//
// One item enters per clock unless the output is held; it passes through decode, product,
// scaling, reciprocal multiply, back multiply, correction and output register stages.
// Reset clears the six stage valid bits; the data registers are not reset.
// When a result is held at the output, the whole pipeline freezes and in_ch.ready
// drops; bubbles move forward while the output is empty or being taken.
`timescale 1ns / 1ps

module wavelength_to_rgb_unit (
  input logic        clk,
  input logic        rst_n,
  w2rgb_in_if.sink   in_ch,
  w2rgb_out_if.source out_ch
);
  import w2rgb_pkg::*;

  localparam int STAGES = 6;

  logic              en;
  logic              in_xfer;
  logic [STAGES-1:0] v_r;
  logic [STAGES-1:0] v_nxt;
  dec_t              dec;

  // Pipeline advances whenever the output register is empty or being drained.
  assign en      = !v_r[STAGES-1] || out_ch.ready;
  assign in_xfer = in_ch.valid && en;
  assign v_nxt   = {v_r[STAGES-2:0], in_ch.valid};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= v_nxt;
    end
  end

  assign in_ch.ready  = en;
  assign out_ch.valid = v_r[STAGES-1];

  w2rgb_decode u_decode (
    .clk           (clk),
    .en            (en),
    .wavelength_nm (in_ch.wavelength_nm),
    .dec_o         (dec)
  );

  w2rgb_chan u_red (
    .clk     (clk),
    .en      (en),
    .seg_i   (dec.seg),
    .num_i   (dec.red_num),
    .inten_i (dec.inten),
    .chan_o  (out_ch.red)
  );

  w2rgb_chan u_green (
    .clk     (clk),
    .en      (en),
    .seg_i   (dec.seg),
    .num_i   (dec.grn_num),
    .inten_i (dec.inten),
    .chan_o  (out_ch.green)
  );

  w2rgb_chan u_blue (
    .clk     (clk),
    .en      (en),
    .seg_i   (dec.seg),
    .num_i   (dec.blu_num),
    .inten_i (dec.inten),
    .chan_o  (out_ch.blue)
  );

  // An accepted transfer occupies the first stage on the next cycle.
  a_enter: assert property (@(posedge clk) disable iff (!rst_n)
    in_xfer |=> v_r[0])
    else $error("accepted item did not enter the first stage");

  // A stall freezes every valid bit.
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !en |=> $stable(v_r))
    else $error("valid bits moved during a stall");

  // A wavelength outside the visible range comes out black once it has moved through every stage without a stall.
  a_black: assert property (@(posedge clk) disable iff (!rst_n)
    (in_xfer && ((in_ch.wavelength_nm < WL_MIN) || (in_ch.wavelength_nm > WL_MAX)))
      ##1 en ##1 en ##1 en ##1 en ##1 en
      |=> (out_ch.valid && (out_ch.red == '0) && (out_ch.green == '0)
           && (out_ch.blue == '0)))
    else $error("out-of-range wavelength did not give black");

endmodule

/* design/w2rgb_decode.sv */
// First pipeline stage: finds the colour segment, the three colour numerators
// and the edge intensity of one wavelength. Depends on w2rgb_pkg.
`timescale 1ns / 1ps

module w2rgb_decode (
  input  logic                           clk,
  input  logic                           en,
  input  logic [w2rgb_pkg::WL_W-1:0]     wavelength_nm,
  output w2rgb_pkg::dec_t                dec_o
);
  import w2rgb_pkg::*;

  dec_t            dec_r;
  dec_t            dec_nxt;
  logic            black;
  logic [WL_W-1:0] diff_hi;
  logic [WL_W-1:0] diff_lo;

  // Segment and numerators; anything outside the visible range maps to black.
  always_comb begin
    black   = (wavelength_nm < WL_MIN) || (wavelength_nm > WL_MAX);
    diff_hi = WL_MAX - wavelength_nm;
    diff_lo = wavelength_nm - WL_MIN;
    dec_nxt = '0;
    priority if (black) begin
      dec_nxt.seg = SEG_RED;
    end else if (wavelength_nm <= WL_VIOLET) begin
      dec_nxt.seg     = SEG_VIOLET;
      dec_nxt.red_num = NUM_W'(WL_VIOLET - wavelength_nm);
      dec_nxt.blu_num = NUM_W'(DEN_VIOLET);
    end else if (wavelength_nm <= WL_BLUE) begin
      dec_nxt.seg     = SEG_BLUE;
      dec_nxt.grn_num = NUM_W'(wavelength_nm - WL_VIOLET);
      dec_nxt.blu_num = NUM_W'(DEN_BLUE);
    end else if (wavelength_nm <= WL_CYAN) begin
      dec_nxt.seg     = SEG_CYAN;
      dec_nxt.grn_num = NUM_W'(DEN_CYAN);
      dec_nxt.blu_num = NUM_W'(WL_CYAN - wavelength_nm);
    end else if (wavelength_nm <= WL_GREEN) begin
      dec_nxt.seg     = SEG_GREEN;
      dec_nxt.red_num = NUM_W'(wavelength_nm - WL_CYAN);
      dec_nxt.grn_num = NUM_W'(DEN_GREEN);
    end else if (wavelength_nm <= WL_YELLOW) begin
      dec_nxt.seg     = SEG_YELLOW;
      dec_nxt.red_num = NUM_W'(DEN_YELLOW);
      dec_nxt.grn_num = NUM_W'(WL_YELLOW - wavelength_nm);
    end else begin
      dec_nxt.seg     = SEG_RED;
      dec_nxt.red_num = NUM_W'(DEN_RED);
    end

    // Intensity falls off linearly toward both ends of the visible range.
    priority if (black) begin
      dec_nxt.inten = INTEN_FULL;
    end else if (wavelength_nm >= WL_RAMP_HI) begin
      dec_nxt.inten = INTEN_FLOOR + INTEN_STEP_HI * diff_hi;
    end else if (wavelength_nm < WL_RAMP_LO) begin
      dec_nxt.inten = INTEN_FLOOR + INTEN_STEP_LO * diff_lo;
    end else begin
      dec_nxt.inten = INTEN_FULL;
    end
  end

  // Stage register, held while the pipeline is stalled.
  always_ff @(posedge clk) begin
    if (en) begin
      dec_r <= dec_nxt;
    end
  end

  assign dec_o = dec_r;

endmodule

/* design/w2rgb_chan.sv */
// Five-stage scaling pipeline for one colour channel: multiply by intensity and
// by 255, then divide by the segment constant with rounding. Depends on w2rgb_pkg.
`timescale 1ns / 1ps

module w2rgb_chan (
  input  logic                              clk,
  input  logic                              en,
  input  w2rgb_pkg::seg_t                   seg_i,
  input  logic [w2rgb_pkg::NUM_W-1:0]       num_i,
  input  logic [w2rgb_pkg::INTEN_W-1:0]     inten_i,
  output logic [w2rgb_pkg::CHAN_W-1:0]      chan_o
);
  import w2rgb_pkg::*;

  // Stage 2: numerator times intensity.
  logic [PROD_W-1:0] p_r;
  logic [PROD_W-1:0] p_nxt;
  seg_t              seg_a_r;
  // Stage 3: doubled scaled numerator plus rounding bias.
  logic [N2_W-1:0]   n2_r;
  logic [N2_W-1:0]   n2_nxt;
  seg_t              seg_b_r;
  // Stage 4: quotient estimate from the reciprocal.
  logic [Q_W-1:0]    q_r;
  logic [Q_W-1:0]    q_nxt;
  logic [N2_W-1:0]   n2_b_r;
  seg_t              seg_c_r;
  logic [N2_W+RECIP_W-1:0] recip_prod;
  // Stage 5: estimate times divisor.
  logic [REM_W-1:0]  qd_r;
  logic [REM_W-1:0]  qd_nxt;
  logic [Q_W-1:0]    q_b_r;
  logic [N2_W-1:0]   n2_c_r;
  seg_t              seg_d_r;
  // Stage 6: one correction step and the output byte.
  logic [CHAN_W-1:0] chan_r;
  logic [CHAN_W-1:0] chan_nxt;
  logic [REM_W-1:0]  rem;
  logic [Q_W-1:0]    q_fix;

  always_comb begin
    p_nxt      = PROD_W'(num_i) * PROD_W'(inten_i);
    // Times 510 as 512 minus 2, plus 800 * den.
    n2_nxt     = N2_W'((REM_W'(p_r) << 9) - (REM_W'(p_r) << 1) + REM_W'(seg_bias(seg_a_r)));
    recip_prod = (N2_W + RECIP_W)'(n2_r) * (N2_W + RECIP_W)'(seg_recip(seg_b_r));
    q_nxt      = recip_prod[RECIP_SHIFT +: Q_W];
    qd_nxt     = REM_W'(q_r) * REM_W'(seg_div(seg_c_r));
    // The estimate is low by at most one; bump it when the remainder reaches the divisor.
    rem        = REM_W'(n2_c_r) - qd_r;
    q_fix      = (rem >= REM_W'(seg_div(seg_d_r))) ? q_b_r + Q_W'(1) : q_b_r;
    chan_nxt   = q_fix[CHAN_W-1:0];
  end

  // All stages advance together under the common enable.
  always_ff @(posedge clk) begin
    if (en) begin
      p_r     <= p_nxt;
      seg_a_r <= seg_i;
      n2_r    <= n2_nxt;
      seg_b_r <= seg_a_r;
      q_r     <= q_nxt;
      n2_b_r  <= n2_r;
      seg_c_r <= seg_b_r;
      qd_r    <= qd_nxt;
      q_b_r   <= q_r;
      n2_c_r  <= n2_b_r;
      seg_d_r <= seg_c_r;
      chan_r  <= chan_nxt;
    end
  end

  assign chan_o = chan_r;

endmodule
